// File: rtl/lmts_pkg.sv
// package: shared types, register indexes and operation codes for the pixel select unit
`timescale 1ns / 1ps
package lmts_pkg;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 16;
  localparam int IDX_W  = 20;

  localparam logic [CFG_AW-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_AW-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_AW-1:0] REG_CONF_THRESH  = 3'd2;
  localparam logic [CFG_AW-1:0] REG_MAX_TRANSFER = 3'd3;
  localparam logic [CFG_AW-1:0] REG_FORCE_ALL    = 3'd4;
  localparam logic [CFG_AW-1:0] REG_EIGHT_CONN   = 3'd5;

  localparam logic [1:0] OP_PIXEL  = 2'd0;
  localparam logic [1:0] OP_DRAIN  = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;

  localparam logic [1:0] LABEL_OPEN = 2'd2;

  localparam logic [3:0] NB_COUNT = 4'd9;

  // row and column offset codes: 0 is one ahead, 1 same, 2 one behind
  typedef struct packed {
    logic [1:0] uy;
    logic [1:0] ux;
  } nb_ofs_t;

  typedef struct packed {
    logic in_ready;
    logic pix_step;
    logic fin_start;
    logic rd_step;
    logic dec_load;
    logic emit_load;
  } lmts_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       skip;
    logic       has_ctr;
    logic       rd_done;
    logic       out_free;
    logic       emit_done;
  } lmts_st_t;

  function automatic nb_ofs_t nb_ofs(input logic [3:0] k);
    nb_ofs_t o;
    case (k)
      4'd1:    o = '{uy: 2'd0, ux: 2'd0};
      4'd2:    o = '{uy: 2'd0, ux: 2'd1};
      4'd3:    o = '{uy: 2'd0, ux: 2'd2};
      4'd4:    o = '{uy: 2'd1, ux: 2'd0};
      4'd5:    o = '{uy: 2'd1, ux: 2'd2};
      4'd6:    o = '{uy: 2'd2, ux: 2'd0};
      4'd7:    o = '{uy: 2'd2, ux: 2'd1};
      4'd8:    o = '{uy: 2'd2, ux: 2'd2};
      default: o = '{uy: 2'd1, ux: 2'd1};
    endcase
    return o;
  endfunction

endpackage

// File: rtl/lmts_if.sv
// interfaces: pixel request channel and result channel
`timescale 1ns / 1ps
interface lmts_in_if #(parameter int CONF_BITS = 16);
  logic                 valid;
  logic                 ready;
  logic [1:0]           operation;
  logic [CONF_BITS-1:0] confidence;
  logic [1:0]           edge_state;
  modport source (output valid, operation, confidence, edge_state, input ready);
  modport sink (input valid, operation, confidence, edge_state, output ready);
endinterface

interface lmts_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [19:0] pixel_index;
  logic        is_local_max;
  logic        selected;
  logic        list_empty;
  logic        last;
  modport source (output valid, kind, pixel_index, is_local_max, selected, list_empty, last,
                  input ready);
  modport sink (input valid, kind, pixel_index, is_local_max, selected, list_empty, last,
                output ready);
endinterface

// File: rtl/local_max_topk_pixel_select_unit.sv
// top level: 3x3 local maximum test with top-k candidate list
`timescale 1ns / 1ps
// Takes one request at a time. A pixel or drain request is taken, writes the line
// ring, reads the centre and its eight neighbours through the ring's single read
// port, then decides and ranks; one that completes no window centre ends after the
// ring write. A finish request is taken and then emits its list one entry per cycle
// while the output register is free. Results wait in an output register; up to one
// waits while the next request is worked on, and a decision or list entry stalls
// until that register is free. Memory: one ring of 2*MAX_WIDTH+4 words, no clearing.
module local_max_topk_pixel_select_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int TOP_K      = 32,
  parameter int CONF_BITS  = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [lmts_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [lmts_pkg::CFG_DW-1:0] cfg_wdata,
  lmts_in_if.sink                     in_req,
  lmts_out_if.source                  out_res
);
  import lmts_pkg::*;

  lmts_cmd_t cmd;
  lmts_st_t  st;
  logic      in_accept;

  assign in_req.ready = cmd.in_ready;
  assign in_accept    = in_req.valid && cmd.in_ready;

  lmts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .st        (st),
    .cmd       (cmd)
  );

  lmts_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .TOP_K      (TOP_K),
    .CONF_BITS  (CONF_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .in_accept        (in_accept),
    .in_operation     (in_req.operation),
    .in_confidence    (in_req.confidence),
    .in_edge_state    (in_req.edge_state),
    .out_ready        (out_res.ready),
    .out_valid        (out_res.valid),
    .out_kind         (out_res.kind),
    .out_pixel_index  (out_res.pixel_index),
    .out_is_local_max (out_res.is_local_max),
    .out_selected     (out_res.selected),
    .out_list_empty   (out_res.list_empty),
    .out_last         (out_res.last),
    .cmd              (cmd),
    .st               (st)
  );
endmodule

// File: rtl/lmts_ram.sv
// generic simple dual port ram with registered read
`timescale 1ns / 1ps
module lmts_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 2052
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/lmts_ctrl.sv
// controller: sequences pixel writes, window reads, decisions and list output
`timescale 1ns / 1ps
module lmts_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_accept,
  input  lmts_pkg::lmts_st_t    st,
  output lmts_pkg::lmts_cmd_t   cmd
);
  import lmts_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DISP = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_DEC  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (in_accept) begin
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        unique case (st.op) inside
          OP_PIXEL, OP_DRAIN: begin
            if (st.skip) begin
              state_nxt = S_IDLE;
            end else begin
              cmd.pix_step = 1'b1;
              state_nxt    = st.has_ctr ? S_RD : S_IDLE;
            end
          end
          OP_FINISH: begin
            cmd.fin_start = 1'b1;
            state_nxt     = S_FIN;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_RD: begin
        cmd.rd_step = 1'b1;
        if (st.rd_done) begin
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (st.out_free) begin
          cmd.dec_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.emit_load = 1'b1;
          if (st.emit_done) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule

// File: rtl/lmts_dp.sv
// datapath: config registers, line ring, window compare, ranked list, result register
`timescale 1ns / 1ps
module lmts_dp #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int TOP_K      = 32,
  parameter int CONF_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [lmts_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [lmts_pkg::CFG_DW-1:0]   cfg_wdata,
  input  logic                          in_accept,
  input  logic [1:0]                    in_operation,
  input  logic [CONF_BITS-1:0]          in_confidence,
  input  logic [1:0]                    in_edge_state,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic                          out_kind,
  output logic [lmts_pkg::IDX_W-1:0]    out_pixel_index,
  output logic                          out_is_local_max,
  output logic                          out_selected,
  output logic                          out_list_empty,
  output logic                          out_last,
  input  lmts_pkg::lmts_cmd_t           cmd,
  output lmts_pkg::lmts_st_t            st
);
  import lmts_pkg::*;

  localparam int RING  = 2 * MAX_WIDTH + 4;
  localparam int AW    = $clog2(RING);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int TW    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int PW    = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 2);
  localparam int CW    = $clog2(TOP_K + 1);
  localparam int IW    = (TOP_K > 1) ? $clog2(TOP_K) : 1;
  localparam int CMPW  = (CONF_BITS > 16) ? CONF_BITS : 16;
  localparam int DW    = CONF_BITS + 2;

  // config
  logic [10:0] fw_r, fh_r;
  logic [15:0] thr_r;
  logic [5:0]  mt_r;
  logic        force_r, eight_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r    <= 11'd1024;
      fh_r    <= 11'd1024;
      thr_r   <= '0;
      mt_r    <= 6'd32;
      force_r <= 1'b0;
      eight_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_FRAME_WIDTH:  fw_r    <= cfg_wdata[10:0];
        REG_FRAME_HEIGHT: fh_r    <= cfg_wdata[10:0];
        REG_CONF_THRESH:  thr_r   <= cfg_wdata[15:0];
        REG_MAX_TRANSFER: mt_r    <= cfg_wdata[5:0];
        REG_FORCE_ALL:    force_r <= cfg_wdata[0];
        REG_EIGHT_CONN:   eight_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // clamped frame size and total
  logic [31:0] w32, h32;
  logic [WW-1:0] w;
  logic [HW-1:0] h;
  logic [TW-1:0] total_r;
  logic [PW-1:0] total_p, w_p;

  always_comb begin
    w32 = (fw_r == 11'd0) ? 32'd1 : ((32'(fw_r) > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : 32'(fw_r));
    h32 = (fh_r == 11'd0) ? 32'd1 :
          ((32'(fh_r) > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : 32'(fh_r));
    w   = w32[WW-1:0];
    h   = h32[HW-1:0];
    total_p = PW'(total_r);
    w_p     = PW'(w);
  end

  always_ff @(posedge clk) begin
    total_r <= TW'(w) * TW'(h);
  end

  // latched request
  logic [1:0]           op_r;
  logic [CONF_BITS-1:0] conf_in_r;
  logic [1:0]           lab_in_r;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r      <= in_operation;
      conf_in_r <= in_confidence;
      lab_in_r  <= in_edge_state;
    end
  end

  // scan state
  logic [PW-1:0] p_r;
  logic [AW-1:0] wp_r, pa_r;
  logic [WW-1:0] cx_r;
  logic [HW-1:0] cy_r;
  logic [TW-1:0] c_r;

  assign st.op      = op_r;
  assign st.skip    = p_r > (total_p + w_p);
  assign st.has_ctr = p_r >= (w_p + PW'(1));

  logic          ram_we;
  logic [DW-1:0] ram_wdata, ram_rdata;
  logic [AW-1:0] ram_raddr;

  assign ram_we    = cmd.pix_step && (p_r < total_p);
  assign ram_wdata = (op_r == OP_PIXEL) ? {lab_in_r, conf_in_r} : '0;

  lmts_ram #(.WIDTH(DW), .DEPTH(RING)) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // window read sequence
  logic [3:0]     k_r;
  nb_ofs_t        ofs;
  logic [AW:0]    nb_dist, pa_ext;
  logic           nb_ok;
  logic           rd_vld_r, rd_first_r;
  logic [CONF_BITS-1:0] ctr_r;
  logic [1:0]     lab_r;
  logic           lm_r;
  logic [CONF_BITS-1:0] rd_conf;

  assign rd_conf = ram_rdata[CONF_BITS-1:0];

  always_comb begin
    ofs = nb_ofs(k_r);
    case (ofs.uy)
      2'd0:    nb_dist = '0;
      2'd1:    nb_dist = (AW+1)'(w);
      default: nb_dist = (AW+1)'({w, 1'b0});
    endcase
    nb_dist = nb_dist + (AW+1)'(ofs.ux);
    pa_ext  = (AW+1)'(pa_r);
    if (pa_ext < nb_dist) begin
      pa_ext = pa_ext + (AW+1)'(RING);
    end
    ram_raddr = AW'(pa_ext - nb_dist);
    nb_ok = k_r < NB_COUNT;
    if (ofs.uy == 2'd0 && (HW+1)'(cy_r) + (HW+1)'(1) >= (HW+1)'(h)) nb_ok = 1'b0;
    if (ofs.uy == 2'd2 && cy_r == '0) nb_ok = 1'b0;
    if (ofs.ux == 2'd0 && (WW+1)'(cx_r) + (WW+1)'(1) >= (WW+1)'(w)) nb_ok = 1'b0;
    if (ofs.ux == 2'd2 && cx_r == '0) nb_ok = 1'b0;
    if (!eight_r && ofs.uy != 2'd1 && ofs.ux != 2'd1) nb_ok = 1'b0;
  end

  assign st.rd_done = (k_r == NB_COUNT);

  always_ff @(posedge clk) begin
    if (cmd.pix_step) begin
      k_r <= '0;
    end else if (cmd.rd_step) begin
      k_r <= k_r + 4'd1;
      rd_vld_r   <= nb_ok;
      rd_first_r <= (k_r == 4'd0);
      if (k_r != 4'd0) begin
        if (rd_first_r) begin
          ctr_r <= rd_conf;
          lab_r <= ram_rdata[DW-1:CONF_BITS];
          lm_r  <= 1'b1;
        end else if (rd_vld_r && rd_conf > ctr_r) begin
          lm_r <= 1'b0;
        end
      end
    end
  end

  // ranked list
  logic [CONF_BITS-1:0] rk_sc_r  [TOP_K];
  logic [IDX_W-1:0]     rk_idx_r [TOP_K];
  logic [CONF_BITS-1:0] rk_sc_nxt  [TOP_K];
  logic [IDX_W-1:0]     rk_idx_nxt [TOP_K];
  logic [TOP_K-1:0]     ge;
  logic [CW-1:0]        cnt_r;
  logic [31:0]          c32;
  logic [IDX_W-1:0]     c_idx;
  logic                 elig, ins;

  assign c32   = 32'(c_r);
  assign c_idx = c32[IDX_W-1:0];
  assign elig  = (lab_r == LABEL_OPEN);
  assign ins   = !force_r && elig && lm_r && (CMPW'(ctr_r) > CMPW'(thr_r));

  always_comb begin
    for (int i = 0; i < TOP_K; i++) begin
      ge[i] = (32'(i) < 32'(cnt_r)) && (rk_sc_r[i] >= ctr_r);
    end
    for (int i = 0; i < TOP_K; i++) begin
      if (ge[i]) begin
        rk_sc_nxt[i]  = rk_sc_r[i];
        rk_idx_nxt[i] = rk_idx_r[i];
      end else if (i == 0) begin
        rk_sc_nxt[i]  = ctr_r;
        rk_idx_nxt[i] = c_idx;
      end else if (ge[(i > 0) ? i - 1 : 0]) begin
        rk_sc_nxt[i]  = ctr_r;
        rk_idx_nxt[i] = c_idx;
      end else begin
        rk_sc_nxt[i]  = rk_sc_r[(i > 0) ? i - 1 : 0];
        rk_idx_nxt[i] = rk_idx_r[(i > 0) ? i - 1 : 0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.dec_load && ins) begin
      for (int i = 0; i < TOP_K; i++) begin
        rk_sc_r[i]  <= rk_sc_nxt[i];
        rk_idx_r[i] <= rk_idx_nxt[i];
      end
    end
  end

  // finish bookkeeping
  logic [6:0] mt_sat, cnt7, keep, keep_r, e_r;
  logic       empty_r;

  always_comb begin
    mt_sat = (7'(mt_r) > 7'(TOP_K)) ? 7'(TOP_K) : 7'(mt_r);
    cnt7   = 7'(cnt_r);
    keep   = (mt_sat > cnt7) ? cnt7 : mt_sat;
  end

  assign st.emit_done = empty_r || (e_r + 7'd1 == keep_r);

  always_ff @(posedge clk) begin
    if (cmd.fin_start) begin
      keep_r  <= keep;
      empty_r <= force_r || (keep == 7'd0);
      e_r     <= '0;
    end else if (cmd.emit_load) begin
      e_r <= e_r + 7'd1;
    end
  end

  // scan and list control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r   <= '0;
      wp_r  <= '0;
      pa_r  <= '0;
      cx_r  <= '0;
      cy_r  <= '0;
      c_r   <= '0;
      cnt_r <= '0;
    end else if (cmd.fin_start) begin
      p_r   <= '0;
      cx_r  <= '0;
      cy_r  <= '0;
      c_r   <= '0;
      cnt_r <= '0;
    end else begin
      if (cmd.pix_step) begin
        p_r  <= p_r + PW'(1);
        pa_r <= wp_r;
        wp_r <= (wp_r == AW'(RING - 1)) ? '0 : wp_r + AW'(1);
      end
      if (cmd.dec_load) begin
        c_r <= c_r + TW'(1);
        if ((WW+1)'(cx_r) + (WW+1)'(1) >= (WW+1)'(w)) begin
          cx_r <= '0;
          cy_r <= cy_r + HW'(1);
        end else begin
          cx_r <= cx_r + WW'(1);
        end
        if (ins && 32'(cnt_r) < 32'(TOP_K)) begin
          cnt_r <= cnt_r + CW'(1);
        end
      end
    end
  end

  // result register
  logic out_valid_r;
  logic load;

  assign load        = cmd.dec_load || cmd.emit_load;
  assign st.out_free = !out_valid_r || out_ready;
  assign out_valid   = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.dec_load) begin
      out_kind         <= 1'b0;
      out_pixel_index  <= c_idx;
      out_is_local_max <= lm_r;
      out_selected     <= force_r && elig;
      out_list_empty   <= 1'b0;
      out_last         <= 1'b0;
    end else if (cmd.emit_load) begin
      out_kind         <= 1'b1;
      out_pixel_index  <= empty_r ? '0 : rk_idx_r[e_r[IW-1:0]];
      out_is_local_max <= !empty_r;
      out_selected     <= !empty_r;
      out_list_empty   <= empty_r;
      out_last         <= st.emit_done;
    end
  end
endmodule

// File: rtl/lmts_chk.sv
// checker: port level properties of the pixel select unit, bound to the top level
`timescale 1ns / 1ps
module lmts_chk (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_kind,
  input logic out_is_local_max,
  input logic out_selected,
  input logic out_list_empty,
  input logic out_last,
  input logic [19:0] out_pixel_index
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_index) && $stable(out_kind))
    else $error("stalled result changed");

  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");

  a_empty_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_list_empty |-> out_kind && out_last && !out_selected &&
    out_pixel_index == 20'd0)
    else $error("bad empty list result");

  a_pixel_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_kind |-> !out_last && !out_list_empty)
    else $error("bad per pixel result");

  a_entry_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind && !out_list_empty |-> out_is_local_max && out_selected)
    else $error("bad list entry");
endmodule

bind local_max_topk_pixel_select_unit lmts_chk u_lmts_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_req.valid),
  .in_ready         (in_req.ready),
  .out_valid        (out_res.valid),
  .out_ready        (out_res.ready),
  .out_kind         (out_res.kind),
  .out_is_local_max (out_res.is_local_max),
  .out_selected     (out_res.selected),
  .out_list_empty   (out_res.list_empty),
  .out_last         (out_res.last),
  .out_pixel_index  (out_res.pixel_index)
);
